FILE: rtl/hrhp_pkg.sv
// Shared constants and helpers for the HTTP request header parser.
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

  localparam int LENGTH_BITS = 32;

  // Parse phases; the low codes double as region tags.
  localparam logic [2:0] PH_METHOD   = 3'd0;
  localparam logic [2:0] PH_ENDPOINT = 3'd1;
  localparam logic [2:0] PH_VERSION  = 3'd2;
  localparam logic [2:0] PH_HEADER   = 3'd3;
  localparam logic [2:0] PH_HOST     = 3'd4;
  localparam logic [2:0] PH_CTYPE    = 3'd5;
  localparam logic [2:0] PH_CLEN     = 3'd6;
  localparam logic [2:0] PH_BODY     = 3'd7;

  localparam logic [3:0] REG_BREAK = 4'd7;
  localparam logic [3:0] REG_BODY  = 4'd8;

  localparam logic [3:0] MTH_INVALID = 4'd0;
  localparam logic [3:0] MTH_CONNECT = 4'd1;
  localparam logic [3:0] MTH_DELETE  = 4'd2;
  localparam logic [3:0] MTH_GET     = 4'd3;
  localparam logic [3:0] MTH_HEAD    = 4'd4;
  localparam logic [3:0] MTH_OPTIONS = 4'd5;
  localparam logic [3:0] MTH_POST    = 4'd6;
  localparam logic [3:0] MTH_PATCH   = 4'd7;
  localparam logic [3:0] MTH_PUT     = 4'd8;
  localparam logic [3:0] MTH_TRACE   = 4'd9;

  // Length value sub-states held in the line position counter.
  localparam logic [4:0] LV_LEAD = 5'd0;
  localparam logic [4:0] LV_DIGS = 5'd1;
  localparam logic [4:0] LV_STOP = 5'd2;

  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_SP  = 8'd32;

  localparam logic [4:0] KEY_HOST_LEN  = 5'd6;
  localparam logic [4:0] KEY_CTYPE_LEN = 5'd14;
  localparam logic [4:0] KEY_CLEN_LEN  = 5'd16;

  localparam logic [47:0]  KEY_HOST  = "Host: ";
  localparam logic [111:0] KEY_CTYPE = "Content-Type: ";
  localparam logic [127:0] KEY_CLEN  = "Content-Length: ";

  typedef logic [7:0] byte_t;

  function automatic byte_t key_char(input logic [1:0] k, input logic [4:0] pos);
    byte_t c;
    c = 8'h00;
    case (k)
      2'd0: if (pos < KEY_HOST_LEN) c = KEY_HOST[8 * (5 - int'(pos)) +: 8];
      2'd1: if (pos < KEY_CTYPE_LEN) c = KEY_CTYPE[8 * (13 - int'(pos)) +: 8];
      2'd2: if (pos < KEY_CLEN_LEN) c = KEY_CLEN[8 * (15 - int'(pos)) +: 8];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] first_letter(input byte_t b);
    logic [3:0] m;
    case (b)
      "C":     m = MTH_CONNECT;
      "D":     m = MTH_DELETE;
      "G":     m = MTH_GET;
      "H":     m = MTH_HEAD;
      "O":     m = MTH_OPTIONS;
      "P":     m = MTH_PUT;
      "T":     m = MTH_TRACE;
      default: m = MTH_INVALID;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/http_request_header_parser.sv
// HTTP/1.1 request header parser: tags each byte of a request stream.
//
// Takes one request byte per transfer and returns one tagged byte per byte:
// the region it belongs to, the method decoded so far, header and message end
// flags, and the Content-Length value (saturated at all ones, with
// length_error on overflow or a minus sign; the last Content-Length line
// wins). Each byte is fully processed in the cycle it is accepted, and the
// result lands in an output register, so the block takes one byte per clock
// whenever the result side keeps up; in_ready drops only while a held result
// is not taken. After message_done the parser is set for the next request.
`timescale 1ns / 1ps
`default_nettype none

module http_request_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       byte_out,
  output logic [3:0]       region,
  output logic [3:0]       method_code,
  output logic             header_done,
  output logic             message_done,
  output logic [31:0]      length_value,
  output logic             length_error
);

  localparam int LB = hrhp_pkg::LENGTH_BITS;

  logic [2:0]    phase, phase_next;
  logic [1:0]    crlf, crlf_next;
  logic [4:0]    lp, lp_next;
  logic [2:0]    mask, mask_next;
  logic [3:0]    method_value, method_next;
  logic [LB-1:0] acc, acc_next;
  logic [LB-1:0] body_rem, body_next;
  logic          fault, fault_next;

  logic          accept;
  logic [3:0]    region_c;
  logic          hd_c, md_c;
  logic          line_end, head_end;
  logic          is_digit;
  logic [LB+3:0] mul10;
  logic          ovf;
  logic [2:0]    hit, done;
  logic [4:0]    lp_inc;
  logic [LB-1:0] rem_dec;
  logic [63:0]   acc_wide;
  logic          acc_hi;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_digit = data_byte inside {["0":"9"]};
  assign mul10 = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{LB{1'b0}}, data_byte[3:0]};
  assign ovf = |mul10[LB+3:LB];
  assign lp_inc = (lp < 5'd31) ? lp + 5'd1 : lp;
  assign rem_dec = (body_rem == '0) ? '0 : body_rem - LB'(1);

  // Saturate the length to the 32-bit output field.
  assign acc_wide = 64'(acc_next);
  assign acc_hi   = |acc_wide[63:32];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hit[k] = mask[k] && (hrhp_pkg::key_char(2'(k), lp) == data_byte);
    end
    done[0] = hit[0] && (lp == hrhp_pkg::KEY_HOST_LEN - 5'd1);
    done[1] = hit[1] && (lp == hrhp_pkg::KEY_CTYPE_LEN - 5'd1);
    done[2] = hit[2] && (lp == hrhp_pkg::KEY_CLEN_LEN - 5'd1);
  end

  always_comb begin
    phase_next  = phase;
    crlf_next   = crlf;
    lp_next     = lp;
    mask_next   = mask;
    method_next = method_value;
    acc_next    = acc;
    body_next   = body_rem;
    fault_next  = fault;
    hd_c        = 1'b0;
    md_c        = 1'b0;
    line_end    = 1'b0;
    head_end    = 1'b0;
    region_c    = {1'b0, phase};

    if (phase == hrhp_pkg::PH_BODY) begin
      region_c  = hrhp_pkg::REG_BODY;
      body_next = rem_dec;
      md_c      = (rem_dec == '0);
    end else begin
      if (data_byte == hrhp_pkg::CH_CR) begin
        crlf_next = (crlf == 2'd2) ? 2'd3 : 2'd1;
      end else if (data_byte == hrhp_pkg::CH_LF) begin
        line_end  = (crlf == 2'd1);
        head_end  = (crlf == 2'd3);
        crlf_next = (crlf == 2'd1) ? 2'd2 : 2'd0;
      end else begin
        crlf_next = 2'd0;
      end

      if (data_byte == hrhp_pkg::CH_CR || data_byte == hrhp_pkg::CH_LF) begin
        region_c = hrhp_pkg::REG_BREAK;
      end

      if (!line_end && !head_end) begin
        case (phase)
          hrhp_pkg::PH_METHOD: begin
            if (lp == 5'd0) begin
              method_next = hrhp_pkg::first_letter(data_byte);
            end else if (lp == 5'd1 && method_value == hrhp_pkg::MTH_PUT) begin
              if (data_byte == "O") method_next = hrhp_pkg::MTH_POST;
              else if (data_byte == "A") method_next = hrhp_pkg::MTH_PATCH;
            end
            lp_next = lp_inc;
            if (data_byte == hrhp_pkg::CH_SP) phase_next = hrhp_pkg::PH_ENDPOINT;
          end
          hrhp_pkg::PH_ENDPOINT: begin
            if (data_byte == hrhp_pkg::CH_SP) phase_next = hrhp_pkg::PH_VERSION;
          end
          hrhp_pkg::PH_HEADER: begin
            mask_next = mask & hit;
            if (|done) begin
              lp_next = 5'd0;
              if (done[0]) phase_next = hrhp_pkg::PH_HOST;
              else if (done[1]) phase_next = hrhp_pkg::PH_CTYPE;
              else begin
                phase_next = hrhp_pkg::PH_CLEN;
                acc_next   = '0;
                fault_next = 1'b0;
              end
            end else begin
              lp_next = lp_inc;
            end
          end
          hrhp_pkg::PH_CLEN: begin
            if (lp == hrhp_pkg::LV_LEAD) begin
              if (data_byte inside {hrhp_pkg::CH_SP,
                                    [hrhp_pkg::CH_TAB:hrhp_pkg::CH_CR]}) begin
                lp_next = lp;
              end else if (data_byte == "+") begin
                lp_next = hrhp_pkg::LV_DIGS;
              end else if (data_byte == "-") begin
                acc_next   = '0;
                fault_next = 1'b1;
                lp_next    = hrhp_pkg::LV_STOP;
              end else if (is_digit) begin
                acc_next   = ovf ? '1 : mul10[LB-1:0];
                fault_next = fault | ovf;
                lp_next    = hrhp_pkg::LV_DIGS;
              end else begin
                lp_next = hrhp_pkg::LV_STOP;
              end
            end else if (lp == hrhp_pkg::LV_DIGS) begin
              if (is_digit) begin
                acc_next   = ovf ? '1 : mul10[LB-1:0];
                fault_next = fault | ovf;
              end else begin
                lp_next = hrhp_pkg::LV_STOP;
              end
            end
          end
          default: begin
          end
        endcase
      end else begin
        region_c = hrhp_pkg::REG_BREAK;
      end

      if (line_end) begin
        phase_next = hrhp_pkg::PH_HEADER;
        lp_next    = 5'd0;
        mask_next  = 3'b111;
      end

      if (head_end) begin
        hd_c      = 1'b1;
        body_next = acc;
        lp_next   = 5'd0;
        mask_next = 3'b111;
        if (acc == '0) md_c = 1'b1;
        else phase_next = hrhp_pkg::PH_BODY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hrhp_pkg::PH_METHOD;
      crlf         <= 2'd0;
      lp           <= 5'd0;
      mask         <= 3'b111;
      method_value <= hrhp_pkg::MTH_INVALID;
      acc          <= '0;
      body_rem     <= '0;
      fault        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        if (md_c) begin
          // Message complete: start over for the next request.
          phase        <= hrhp_pkg::PH_METHOD;
          crlf         <= 2'd0;
          lp           <= 5'd0;
          mask         <= 3'b111;
          method_value <= hrhp_pkg::MTH_INVALID;
          acc          <= '0;
          body_rem     <= '0;
          fault        <= 1'b0;
        end else begin
          phase        <= phase_next;
          crlf         <= crlf_next;
          lp           <= lp_next;
          mask         <= mask_next;
          method_value <= method_next;
          acc          <= acc_next;
          body_rem     <= body_next;
          fault        <= fault_next;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_out     <= data_byte;
      region       <= region_c;
      method_code  <= method_next;
      header_done  <= hd_c;
      message_done <= md_c;
      length_value <= acc_hi ? 32'hFFFF_FFFF : acc_wide[31:0];
      length_error <= fault_next | acc_hi;
    end
  end

`ifndef ASSERT_OFF
  a_hd_break: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_done |-> region == hrhp_pkg::REG_BREAK)
    else $error("header end not tagged as line break");

  a_body_no_hd: assert property (@(posedge clk) disable iff (rst)
    out_valid && region == hrhp_pkg::REG_BODY |-> !header_done)
    else $error("header end flagged on body byte");

  a_md_restart: assert property (@(posedge clk) disable iff (rst)
    accept && md_c |=> phase == hrhp_pkg::PH_METHOD && acc == '0 && !fault)
    else $error("parser not restarted after message end");

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == hrhp_pkg::PH_BODY |-> body_rem != '0)
    else $error("body phase with nothing remaining");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Testbench for the HTTP request header parser: directed and random request streams.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  region;
    logic [3:0]  method_code;
    logic        header_done;
    logic        message_done;
    logic [31:0] length_value;
    logic        length_error;
  } byte_tag_t;

  // Tracks the parse of the request stream and holds the tags still to come out.
  class byte_tag_tracker;
    byte_tag_t   tags_due[$];
    int          mismatches;
    logic [2:0]  stage;
    logic [1:0]  crlf_seen;
    logic [4:0]  line_pos;
    logic [2:0]  names_live;
    logic [3:0]  method;
    logic [31:0] clen;
    logic [31:0] body_left;
    logic        clen_bad;
    string       key_name[3];
    logic [2:0]  key_stage[3];

    function new();
      key_name   = '{"Host: ", "Content-Type: ", "Content-Length: "};
      key_stage  = '{hrhp_pkg::PH_HOST, hrhp_pkg::PH_CTYPE, hrhp_pkg::PH_CLEN};
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      stage      = hrhp_pkg::PH_METHOD;
      crlf_seen  = 2'd0;
      line_pos   = 5'd0;
      names_live = 3'b111;
      method     = hrhp_pkg::MTH_INVALID;
      clen       = '0;
      body_left  = '0;
      clen_bad   = 1'b0;
    endfunction

    function logic [3:0] method_of_letter(hrhp_pkg::byte_t b);
      case (b)
        "C":     return hrhp_pkg::MTH_CONNECT;
        "D":     return hrhp_pkg::MTH_DELETE;
        "G":     return hrhp_pkg::MTH_GET;
        "H":     return hrhp_pkg::MTH_HEAD;
        "O":     return hrhp_pkg::MTH_OPTIONS;
        "P":     return hrhp_pkg::MTH_PUT;
        "T":     return hrhp_pkg::MTH_TRACE;
        default: return hrhp_pkg::MTH_INVALID;
      endcase
    endfunction

    // Saturate at all ones and flag the overflow.
    function void add_digit(logic [31:0] d);
      if (clen > (32'hFFFF_FFFF - d) / 32'd10) begin
        clen     = 32'hFFFF_FFFF;
        clen_bad = 1'b1;
      end else begin
        clen = clen * 32'd10 + d;
      end
    endfunction

    function void step_length(hrhp_pkg::byte_t b);
      bit digit;
      digit = (b >= "0" && b <= "9");
      case (line_pos)
        hrhp_pkg::LV_LEAD: begin
          if (b == hrhp_pkg::CH_SP || (b >= hrhp_pkg::CH_TAB && b <= hrhp_pkg::CH_CR)) begin
            // skip leading white space
          end else if (b == "+") begin
            line_pos = hrhp_pkg::LV_DIGS;
          end else if (b == "-") begin
            clen     = '0;
            clen_bad = 1'b1;
            line_pos = hrhp_pkg::LV_STOP;
          end else if (digit) begin
            add_digit(32'(b - "0"));
            line_pos = hrhp_pkg::LV_DIGS;
          end else begin
            line_pos = hrhp_pkg::LV_STOP;
          end
        end
        hrhp_pkg::LV_DIGS: begin
          if (digit) add_digit(32'(b - "0"));
          else line_pos = hrhp_pkg::LV_STOP;
        end
        default: ;
      endcase
    endfunction

    function void step_name(hrhp_pkg::byte_t b);
      int p;
      p = line_pos;
      for (int k = 0; k < 3; k++) begin
        if (!names_live[k]) continue;
        if (p >= key_name[k].len() || key_name[k][p] != b) begin
          names_live[k] = 1'b0;
        end else if (p + 1 == key_name[k].len()) begin
          stage    = key_stage[k];
          line_pos = 5'd0;
          if (key_stage[k] == hrhp_pkg::PH_CLEN) begin
            clen     = '0;
            clen_bad = 1'b0;
          end
          return;
        end
      end
      if (line_pos < 5'd31) line_pos++;
    endfunction

    function void step_stage(hrhp_pkg::byte_t b);
      case (stage)
        hrhp_pkg::PH_METHOD: begin
          if (line_pos == 5'd0) begin
            method = method_of_letter(b);
          end else if (line_pos == 5'd1 && method == hrhp_pkg::MTH_PUT) begin
            if (b == "O") method = hrhp_pkg::MTH_POST;
            else if (b == "A") method = hrhp_pkg::MTH_PATCH;
          end
          if (line_pos < 5'd31) line_pos++;
          if (b == hrhp_pkg::CH_SP) stage = hrhp_pkg::PH_ENDPOINT;
        end
        hrhp_pkg::PH_ENDPOINT: if (b == hrhp_pkg::CH_SP) stage = hrhp_pkg::PH_VERSION;
        hrhp_pkg::PH_HEADER:   step_name(b);
        hrhp_pkg::PH_CLEN:     step_length(b);
        default: ;
      endcase
    endfunction

    function byte_tag_t tag_byte(hrhp_pkg::byte_t b);
      byte_tag_t t;
      bit        line_end;
      bit        head_end;
      logic [1:0] c;
      t          = '0;
      t.byte_out = b;
      line_end   = 1'b0;
      head_end   = 1'b0;
      if (stage == hrhp_pkg::PH_BODY) begin
        t.region = hrhp_pkg::REG_BODY;
        if (body_left != 0) body_left--;
        if (body_left == 0) t.message_done = 1'b1;
      end else begin
        c = crlf_seen;
        if (b == hrhp_pkg::CH_CR) begin
          crlf_seen = (c == 2'd2) ? 2'd3 : 2'd1;
        end else if (b == hrhp_pkg::CH_LF) begin
          line_end  = (c == 2'd1);
          head_end  = (c == 2'd3);
          crlf_seen = (c == 2'd1) ? 2'd2 : 2'd0;
        end else begin
          crlf_seen = 2'd0;
        end
        if (line_end || head_end) begin
          t.region = hrhp_pkg::REG_BREAK;
        end else begin
          t.region = {1'b0, stage};
          step_stage(b);
          if (b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF) t.region = hrhp_pkg::REG_BREAK;
        end
        if (line_end) begin
          stage      = hrhp_pkg::PH_HEADER;
          line_pos   = 5'd0;
          names_live = 3'b111;
        end
        if (head_end) begin
          t.header_done = 1'b1;
          body_left     = clen;
          line_pos      = 5'd0;
          names_live    = 3'b111;
          if (body_left == 0) t.message_done = 1'b1;
          else stage = hrhp_pkg::PH_BODY;
        end
      end
      t.method_code  = method;
      t.length_value = clen;
      t.length_error = clen_bad;
      if (t.message_done) restart();
      return t;
    endfunction

    function void take_byte(hrhp_pkg::byte_t b);
      tags_due.push_back(tag_byte(b));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_tag(byte_tag_t got);
      byte_tag_t want;
      if (tags_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %0h", $time,
                 got.byte_out);
        mismatches++;
        return;
      end
      want = tags_due.pop_front();
      compare_field("byte_out", want.byte_out, got.byte_out);
      compare_field("region", want.region, got.region);
      compare_field("method_code", want.method_code, got.method_code);
      compare_field("header_done", want.header_done, got.header_done);
      compare_field("message_done", want.message_done, got.message_done);
      compare_field("length_value", want.length_value, got.length_value);
      compare_field("length_error", want.length_error, got.length_error);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  byte_out;
  logic [3:0]  region;
  logic [3:0]  method_code;
  logic        header_done;
  logic        message_done;
  logic [31:0] length_value;
  logic        length_error;

  byte_tag_tracker tracker = new();

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int bytes_sent    = 0;
  int in_idle_by_phase[4]   = '{0, 64, 0, 13};
  int out_stall_by_phase[4] = '{0, 0, 64, 13};

  string verbs[12] = '{"CONNECT", "DELETE", "GET", "HEAD", "OPTIONS", "POST", "PATCH",
                       "PUT", "P", "TRACE", "PO", "get"};
  string near_names[8] = '{"host: x", "Host:x", "Hostname: y", "Content-Length:5",
                           "Content-Lengthy: 7", "Content-Type 5", "X-Host: z",
                           "Content-Length : 3"};
  string big_values[4] = '{"4294967295", "4294967296", "99999999999999999999",
                           "0004294967294"};
  hrhp_pkg::byte_t lead_space[5] = '{hrhp_pkg::CH_SP, hrhp_pkg::CH_TAB, hrhp_pkg::CH_LF,
                                     8'd11, 8'd12};

  http_request_header_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_out     (byte_out),
    .region       (region),
    .method_code  (method_code),
    .header_done  (header_done),
    .message_done (message_done),
    .length_value (length_value),
    .length_error (length_error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check each result transfer, then pick the next ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.match_tag(byte_tag_t'({byte_out, region, method_code, header_done,
                                     message_done, length_value, length_error}));
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic send_byte(hrhp_pkg::byte_t b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(hrhp_pkg::CH_CR);
    send_byte(hrhp_pkg::CH_LF);
  endtask

  // Close the header and feed the body until the parser is back at a request start.
  task automatic finish_message();
    int n;
    n = 0;
    if (tracker.clen > 32'd64) send_line("Content-Length: 5");
    send_byte(hrhp_pkg::CH_CR);
    send_byte(hrhp_pkg::CH_LF);
    while (tracker.stage == hrhp_pkg::PH_BODY) begin
      send_byte(n == 0 ? 8'h00 : (n == 1 ? 8'hFF : 8'($urandom_range(255))));
      n++;
    end
  endtask

  function automatic void push_text(ref hrhp_pkg::byte_t q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void push_crlf(ref hrhp_pkg::byte_t q[$]);
    q.push_back(hrhp_pkg::CH_CR);
    q.push_back(hrhp_pkg::CH_LF);
  endfunction

  // Build a request without its closing blank line.
  function automatic void build_request(ref hrhp_pkg::byte_t q[$], input bit with_length);
    int k;
    int shape;
    k = $urandom_range(13);
    if (k < 12) push_text(q, verbs[k]);
    else if (k == 12) repeat ($urandom_range(1, 5)) q.push_back(8'($urandom_range(33, 126)));
    shape = $urandom_range(9);
    if (shape != 0) begin
      q.push_back(hrhp_pkg::CH_SP);
      q.push_back("/");
      repeat ($urandom_range(0, 10)) begin
        if ($urandom_range(9) == 0) q.push_back(8'($urandom_range(255)));
        else q.push_back(8'($urandom_range(33, 126)));
      end
      if (shape != 1) begin
        q.push_back(hrhp_pkg::CH_SP);
        push_text(q, "HTTP/1.1");
      end
    end
    push_crlf(q);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(with_length ? 7 : 3))
        0: begin
          push_text(q, "Host: ");
          repeat ($urandom_range(1, 15)) q.push_back(8'($urandom_range(33, 126)));
        end
        1: push_text(q, "Content-Type: text/plain");
        2: push_text(q, near_names[$urandom_range(7)]);
        3: begin
          // long lines run the position counter into saturation
          push_text(q, "X-Pad: ");
          repeat ($urandom_range(0, 40)) q.push_back(8'($urandom_range(32, 126)));
        end
        5: begin
          push_text(q, "Content-Length: ");
          repeat ($urandom_range(0, 3)) q.push_back(lead_space[$urandom_range(4)]);
          case ($urandom_range(3))
            0: q.push_back("+");
            1: q.push_back("-");
            default: ;
          endcase
          if ($urandom_range(1)) push_text(q, "00");
          push_text(q, $sformatf("%0d", $urandom_range(0, 24)));
          if ($urandom_range(1)) repeat ($urandom_range(1, 3))
            q.push_back(8'($urandom_range(65, 90)));
        end
        6: begin
          // follow a huge value with a small one so the body stays short
          push_text(q, {"Content-Length: ", big_values[$urandom_range(3)]});
          push_crlf(q);
          push_text(q, $sformatf("Content-Length: %0d", $urandom_range(0, 24)));
        end
        default: push_text(q, $sformatf("Content-Length: %0d", $urandom_range(0, 24)));
      endcase
      push_crlf(q);
    end
  endfunction

  task automatic send_random_message();
    hrhp_pkg::byte_t msg[$];
    int    kind;
    int    cut;
    kind = $urandom_range(99);
    if (kind < 80) begin
      build_request(msg, 1'b1);
      foreach (msg[i]) send_byte(msg[i]);
      finish_message();
    end else if (kind < 92) begin
      // drop the tail of a request that carries no length line
      build_request(msg, 1'b0);
      cut = $urandom_range(msg.size() - 1);
      for (int i = 0; i < cut; i++) send_byte(msg[i]);
    end else begin
      repeat ($urandom_range(1, 24)) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic run_directed();
    send_line("CONNECT h:1 HTTP/1.1");
    send_line("Host: h");
    finish_message();
    send_line("DELETE /x HTTP/1.1");
    send_line("Content-Type: a/b");
    finish_message();
    send_line("GET / HTTP/1.1");
    send_line("Content-Length: 2");
    finish_message();
    send_line("HEAD");
    finish_message();
    send_line("OPTIONS * HTTP/1.1");
    send_line("Content-Length: \t\v+3x");
    finish_message();
    send_line("POST /p HTTP/1.1");
    send_line("Content-Length: -7");
    finish_message();
    send_line("PATCH /q HTTP/1.1");
    send_line("Content-Length: 4294967295");
    send_line("Content-Length: 4294967296");
    send_line("Content-Length: \0151");
    finish_message();
    send_line("PX /r HTTP/1.1");
    send_line("host: x");
    send_line("Content-Lengthy: 9");
    finish_message();
    send_line("TRACE ?a\015b\012c HTTP/1.1");
    finish_message();
    send_line("#bad / HTTP/1.1");
    finish_message();
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct   = in_idle_by_phase[ph];
      out_stall_pct = out_stall_by_phase[ph];
      target        = bytes_sent + 390;
      while (bytes_sent < target) send_random_message();
    end
    in_valid <= 1'b0;
    while (tracker.tags_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.tags_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
